### src/cdf_pkg.sv
`timescale 1ns / 1ps
package cdf_pkg;

  localparam int PAYLOAD_DEPTH = 256;
  localparam int ADDR_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] SYNC_FIRST = 8'h5A;
  localparam logic [7:0] SYNC_SECOND = 8'hA5;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'h0000;
  localparam logic [15:0] CRC_TOP = 16'h8000;

  localparam logic [1:0] OP_WR = 2'd0;
  localparam logic [1:0] OP_RD = 2'd1;
  localparam logic [1:0] OP_FRM = 2'd2;

  localparam logic RES_FRAME = 1'b0;
  localparam logic RES_READ = 1'b1;

  localparam logic CMD_RX = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic [1:0] kind;
    logic oob;
    logic [7:0] addr;
    logic [7:0] data;
    logic [7:0] len;
  } op_t;

  function automatic logic [15:0] crc_add_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

### src/cdf_ram.sv
`timescale 1ns / 1ps
module cdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/cdf_front.sv
`timescale 1ns / 1ps
module cdf_front import cdf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [7:0]  rx_byte,
  input  logic [7:0]  read_index,
  output logic        op_valid,
  output op_t         op,
  input  logic        op_ready
);

  localparam logic [1:0] H_SYNC1 = 2'd0;
  localparam logic [1:0] H_SYNC2 = 2'd1;
  localparam logic [1:0] H_LEN = 2'd2;
  localparam logic [1:0] H_BODY = 2'd3;

  logic [1:0]  hunt_state, hunt_state_next;
  logic [7:0]  frame_length, frame_length_next;
  logic [7:0]  body_count, body_count_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  crc_low, crc_low_next;
  logic [7:0]  type_held, type_held_next;

  logic       acc;
  logic [8:0] pos9, len9, pay_idx;
  logic       len_ok, crc_region, last;

  assign in_ready = op_ready;
  assign acc = in_valid && op_ready;

  assign pos9 = {1'b0, body_count};
  assign len9 = {1'b0, frame_length};
  assign pay_idx = pos9 - 9'd2;
  assign len_ok = frame_length >= 8'd4;
  assign crc_region = pos9 < (len9 - 9'd2);
  assign last = (pos9 + 9'd1) >= len9;

  always_comb begin
    hunt_state_next = hunt_state;
    frame_length_next = frame_length;
    body_count_next = body_count;
    running_crc_next = running_crc;
    crc_low_next = crc_low;
    type_held_next = type_held;
    op_valid = 1'b0;
    op = '0;
    if (cmd == CMD_READ) begin
      op_valid = acc;
      op.kind = OP_RD;
      op.addr = read_index;
      op.oob = !({1'b0, read_index} < 9'(PAYLOAD_DEPTH));
    end else begin
      case (hunt_state)
        H_SYNC1: begin
          if (rx_byte == SYNC_FIRST) hunt_state_next = H_SYNC2;
        end
        H_SYNC2: begin
          if (rx_byte == SYNC_SECOND) hunt_state_next = H_LEN;
          else if (rx_byte != SYNC_FIRST) hunt_state_next = H_SYNC1;
        end
        H_LEN: begin
          frame_length_next = rx_byte;
          body_count_next = 8'd0;
          running_crc_next = CRC_INIT;
          hunt_state_next = (rx_byte == 8'd0) ? H_SYNC1 : H_BODY;
        end
        default: begin
          if (len_ok) begin
            if (crc_region) begin
              running_crc_next = crc_add_byte(running_crc, rx_byte);
              if (body_count == 8'd0) begin
                type_held_next = rx_byte;
              end else if (body_count >= 8'd2 && pay_idx < 9'(PAYLOAD_DEPTH)) begin
                op_valid = acc;
                op.kind = OP_WR;
                op.addr = pay_idx[7:0];
                op.data = rx_byte;
              end
            end else if (pos9 == len9 - 9'd2) begin
              crc_low_next = rx_byte;
            end
          end
          body_count_next = body_count + 8'd1;
          if (last) begin
            hunt_state_next = H_SYNC1;
            if (len_ok && {rx_byte, crc_low} == running_crc) begin
              op_valid = acc;
              op.kind = OP_FRM;
              op.data = type_held;
              op.len = frame_length - 8'd4;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hunt_state <= H_SYNC1;
      frame_length <= 8'd0;
      body_count <= 8'd0;
      running_crc <= CRC_INIT;
      crc_low <= 8'd0;
      type_held <= 8'd0;
    end else if (acc) begin
      hunt_state <= hunt_state_next;
      frame_length <= frame_length_next;
      body_count <= body_count_next;
      running_crc <= running_crc_next;
      crc_low <= crc_low_next;
      type_held <= type_held_next;
    end
  end

endmodule

### src/cdf_queue.sv
`timescale 1ns / 1ps
module cdf_queue import cdf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  op_t  in_op,
  output logic in_ready,
  output logic out_valid,
  output op_t  out_op,
  input  logic out_ready
);

  op_t slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic push, pop;

  assign in_ready = count < (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign out_op = slots[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### src/cdf_back.sv
`timescale 1ns / 1ps
module cdf_back import cdf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  op_t         in_op,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [23:0] out_data
);

  logic       op_res, out_free, p_adv, pop;
  logic       p_valid, p_kind, p_oob;
  logic [7:0] p_type, p_len;
  logic [7:0] rdata;

  assign op_res = in_op.kind != OP_WR;
  assign out_free = !out_valid || out_ready;
  assign p_adv = p_valid && out_free;
  assign in_ready = !op_res || !p_valid || out_free;
  assign pop = in_valid && in_ready;

  cdf_ram #(.WIDTH(8), .DEPTH(PAYLOAD_DEPTH)) u_store (
    .clk   (clk),
    .we    (pop && in_op.kind == OP_WR),
    .waddr (in_op.addr[ADDR_W-1:0]),
    .wdata (in_op.data),
    .re    (pop && in_op.kind == OP_RD),
    .raddr (in_op.addr[ADDR_W-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (pop && op_res) begin
      p_valid <= 1'b1;
    end else if (p_adv) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && op_res) begin
      p_kind <= (in_op.kind == OP_RD) ? RES_READ : RES_FRAME;
      p_oob <= in_op.oob;
      p_type <= in_op.data;
      p_len <= in_op.len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (p_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_adv) begin
      out_kind <= p_kind;
      if (p_kind == RES_READ) begin
        out_data <= {(p_oob ? 8'h00 : rdata), 16'h0000};
      end else begin
        out_data <= {8'h00, p_len, p_type};
      end
    end
  end

endmodule

### src/crc16_frame_deframer_top.sv
`timescale 1ns / 1ps
// Receive deframer for 0x5A 0xA5 sync, length-prefixed frames with CRC-16/XMODEM.
// Input stream (s_axis): one request per item. tuser = cmd: 0 feeds rx_byte
// from the line, 1 reads the stored payload byte at read_index.
// Output stream (m_axis): tuser = result_kind, 0 for a good frame (frame_type,
// payload_bytes), 1 for read data. Bad CRC or short frames give nothing.
// One request per cycle sustained while m_axis_tready is high; a taken request
// passes through the queue write on the accepting edge, the result stage with
// the payload RAM read, then the output register before m_axis_tvalid rises.
// The front end runs the sync hunt and CRC and posts store writes, reads and
// frame results into a 4-entry op queue; the back end executes them in order
// against the payload RAM, so reads always see earlier writes.
// Reset clears the hunt state, CRC, queue and output; payload RAM contents
// are undefined until written.
// When m_axis_tready is low the output register and result stage hold, the
// back end stops at the next result op, the queue fills with up to 4 ops and
// s_axis_tready stays low until the output drains.
module crc16_frame_deframer_top import cdf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // rx_byte[7:0], read_index[15:8]
  input  logic        s_axis_tuser,  // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // frame_type[7:0], payload_bytes[15:8], read_data[23:16]
  output logic        m_axis_tuser   // result_kind
);

  logic f_valid, f_ready, q_valid, q_ready;
  op_t  f_op, q_op;

  cdf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .cmd        (s_axis_tuser),
    .rx_byte    (s_axis_tdata[7:0]),
    .read_index (s_axis_tdata[15:8]),
    .op_valid   (f_valid),
    .op         (f_op),
    .op_ready   (f_ready)
  );

  cdf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_op     (f_op),
    .in_ready  (f_ready),
    .out_valid (q_valid),
    .out_op    (q_op),
    .out_ready (q_ready)
  );

  cdf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_op     (q_op),
    .in_ready  (q_ready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_kind  (m_axis_tuser),
    .out_data  (m_axis_tdata)
  );

endmodule
